// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on clk, ignored while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/app_pkg.sv =====
`default_nettype none

package app_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_W         = 35;
    localparam int XY_W          = 34;
    localparam int QW            = 33;
    localparam int FW            = QW + 1;
    localparam int MOD_STEPS     = 7;
    localparam int CL            = CORDIC_STAGES + 1;
    localparam int DL            = QW + 2;
    localparam int CH_W          = 36;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [XY_W-1:0]  xy_t;

    localparam ang_t PI         = 35'sd3373259426;
    localparam ang_t HALF_PI    = 35'sd1686629713;
    localparam ang_t TWO_PI     = 35'sd6746518852;
    localparam ang_t SMALL_TURN = 35'sd10737418;
    localparam xy_t  GAIN       = 34'sd652032874;

    localparam logic [39:0] TWO_PI_MAG = 40'd6746518852;
    localparam logic [15:0] SHORT_TIME = 16'd52;

    typedef enum logic {
        REG_SPEED = 1'b0,
        REG_TURN  = 1'b1
    } reg_idx_t;

    // atan(2^-k) in Q30 radians
    function automatic ang_t atan_q30(input int k);
        ang_t r;
        case (k)
            0:  r = 35'sd843314856;
            1:  r = 35'sd497837829;
            2:  r = 35'sd263043836;
            3:  r = 35'sd133525158;
            4:  r = 35'sd67021686;
            5:  r = 35'sd33543515;
            6:  r = 35'sd16775850;
            7:  r = 35'sd8388437;
            8:  r = 35'sd4194282;
            9:  r = 35'sd2097149;
            10: r = 35'sd1048575;
            11: r = 35'sd524287;
            12: r = 35'sd262143;
            13: r = 35'sd131071;
            14: r = 35'sd65535;
            15: r = 35'sd32767;
            16: r = 35'sd16383;
            17: r = 35'sd8191;
            18: r = 35'sd4095;
            19: r = 35'sd2047;
            20: r = 35'sd1023;
            21: r = 35'sd511;
            22: r = 35'sd255;
            23: r = 35'sd127;
            24: r = 35'sd63;
            25: r = 35'sd31;
            26: r = 35'sd15;
            27: r = 35'sd7;
            28: r = 35'sd3;
            29: r = 35'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // one fold into (-pi, pi]; input within (-3pi, 3pi]
    function automatic ang_t wrap_pi(input ang_t a);
        ang_t r;
        if (a > PI)
            r = a - TWO_PI;
        else if (a <= -PI)
            r = a + TWO_PI;
        else
            r = a;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/app_cordic.sv =====
`default_nettype none

module app_cordic (
    input  wire logic        clk,
    input  wire logic        en,
    input  app_pkg::ang_t    ang,
    output app_pkg::xy_t     cos_val,
    output app_pkg::xy_t     sin_val
);

    app_pkg::ang_t z0;
    logic          neg0;

    app_pkg::xy_t  x_reg [app_pkg::CORDIC_STAGES];
    app_pkg::xy_t  y_reg [app_pkg::CORDIC_STAGES];
    app_pkg::ang_t z_reg [app_pkg::CORDIC_STAGES-1];
    logic          n_reg [app_pkg::CORDIC_STAGES];
    app_pkg::xy_t  cos_reg, sin_reg;

    // fold outer half-plane onto the inner one, negate at the end
    always_comb
    begin
        if (ang > app_pkg::HALF_PI)
        begin
            z0   = ang - app_pkg::PI;
            neg0 = 1'b1;
        end
        else if (ang < -app_pkg::HALF_PI)
        begin
            z0   = ang + app_pkg::PI;
            neg0 = 1'b1;
        end
        else
        begin
            z0   = ang;
            neg0 = 1'b0;
        end
    end

    for (genvar i = 0; i < app_pkg::CORDIC_STAGES; i++)
    begin : g_st
        app_pkg::xy_t  xi, yi;
        app_pkg::ang_t zi;
        logic          ni;

        if (i == 0)
        begin : g_first
            assign xi = app_pkg::GAIN;
            assign yi = '0;
            assign zi = z0;
            assign ni = neg0;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = n_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zi >= 0)
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                end
                n_reg[i] <= ni;
            end
        end

        if (i < app_pkg::CORDIC_STAGES - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (zi >= 0)
                        z_reg[i] <= zi - app_pkg::atan_q30(i);
                    else
                        z_reg[i] <= zi + app_pkg::atan_q30(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (n_reg[app_pkg::CORDIC_STAGES-1])
            begin
                cos_reg <= -x_reg[app_pkg::CORDIC_STAGES-1];
                sin_reg <= -y_reg[app_pkg::CORDIC_STAGES-1];
            end
            else
            begin
                cos_reg <= x_reg[app_pkg::CORDIC_STAGES-1];
                sin_reg <= y_reg[app_pkg::CORDIC_STAGES-1];
            end
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

`default_nettype wire

// ===== rtl/app_div.sv =====
`default_nettype none

// Pipelined restoring divide, quotient truncated toward zero.
// quot = (num * 2^30) / den
module app_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  app_pkg::xy_t                       num,
    input  app_pkg::ang_t                      den,
    output logic signed [app_pkg::FW-1:0]      quot
);

    localparam int RW = app_pkg::ANG_W + app_pkg::QW;

    logic [app_pkg::XY_W-1:0]  nmag;
    logic [app_pkg::ANG_W-1:0] dmag;

    logic [RW-1:0]             n_reg;
    logic [app_pkg::ANG_W-1:0] d0_reg;
    logic                      neg0_reg;

    logic [RW-1:0]             r_reg [app_pkg::QW-1];
    logic [app_pkg::ANG_W-1:0] d_reg [app_pkg::QW-1];
    logic [app_pkg::QW-1:0]    q_reg [app_pkg::QW];
    logic                      neg_reg [app_pkg::QW];
    logic signed [app_pkg::FW-1:0] quot_reg;

    assign nmag = num[app_pkg::XY_W-1] ? -num : num;
    assign dmag = den[app_pkg::ANG_W-1] ? -den : den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= RW'(nmag) << 30;
            d0_reg   <= dmag;
            neg0_reg <= num[app_pkg::XY_W-1] ^ den[app_pkg::ANG_W-1];
        end
    end

    for (genvar j = 0; j < app_pkg::QW; j++)
    begin : g_step
        localparam int B = app_pkg::QW - 1 - j;
        logic [RW-1:0]             ri;
        logic [app_pkg::ANG_W-1:0] di;
        logic [app_pkg::QW-1:0]    qi;
        logic                      ni;
        logic [RW-1:0]             trial;
        logic                      fits;

        if (j == 0)
        begin : g_first
            assign ri = n_reg;
            assign di = d0_reg;
            assign qi = '0;
            assign ni = neg0_reg;
        end
        else
        begin : g_rest
            assign ri = r_reg[j-1];
            assign di = d_reg[j-1];
            assign qi = q_reg[j-1];
            assign ni = neg_reg[j-1];
        end

        assign trial = RW'(di) << B;
        assign fits  = ri >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]   <= fits ? (qi | (app_pkg::QW'(1) << B)) : qi;
                neg_reg[j] <= ni;
            end
        end

        if (j < app_pkg::QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j] <= fits ? (ri - trial) : ri;
                    d_reg[j] <= di;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[app_pkg::QW-1])
                quot_reg <= -$signed({1'b0, q_reg[app_pkg::QW-1]});
            else
                quot_reg <= $signed({1'b0, q_reg[app_pkg::QW-1]});
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/arc_pose_predictor.sv =====
// Arc pose predictor. Each input word is a start pose (x, y in Q15.16 m,
// heading in Q2.13 rad) plus an elapsed time in 1/1024 s; the block moves
// it along a circular arc at the programmed linear speed and turn rate and
// returns the end pose (x, y saturated to 32 bits, heading wrapped to
// (-pi, pi]). Times under 52 ticks use a straight step along the start
// heading; turns under 0.01 rad use the travel itself as chord. One word is
// taken per clock while the output word is not held. The divider that forms
// sin(a)/a (one quotient bit per stage) is the longest part of the
// pipeline. The pipeline advances as a whole: when the output word is held,
// every stage holds. Speed and turn rate are written over the APB port at
// 0x0 and 0x4 and should only change while no word is in flight.
`default_nettype none
`include "assert_macros.svh"

module arc_pose_predictor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] start_x, [63:32] start_y, [79:64] start_heading, [95:80] elapsed_time
    input  wire logic [95:0] s_tdata,
    // stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] end_x, [63:32] end_y, [79:64] end_heading
    output logic [79:0]      m_tdata,
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ds;
        app_pkg::ang_t      th;
        logic               straight;
        logic               dneg;
    } pre_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ds;
        app_pkg::ang_t      half;
        app_pkg::ang_t      hd_ang;
        logic               chord_ds;
    } side_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ds;
        app_pkg::ang_t      hd_ang;
        logic               chord_ds;
        app_pkg::xy_t       c;
        app_pkg::xy_t       s;
    } join_t;

    logic en;

    // ---------------- configuration ----------------
    logic signed [15:0] speed_reg, turn_reg;
    app_pkg::reg_idx_t  reg_sel;

    assign reg_sel = app_pkg::reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 16'sd819;
            turn_reg  <= 16'sd819;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                app_pkg::REG_SPEED: speed_reg <= pwdata[15:0];
                app_pkg::REG_TURN:  turn_reg  <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            app_pkg::REG_SPEED: prdata = {16'h0, speed_reg};
            app_pkg::REG_TURN:  prdata = {16'h0, turn_reg};
        endcase
    end

    // ---------------- stage 1: products, heading fold ----------------
    logic signed [31:0] in_x, in_y;
    logic signed [15:0] in_hd;
    logic [15:0]        in_t;
    logic signed [32:0] ds_full;
    logic signed [16:0] tw;
    logic [16:0]        wabs;
    logic [32:0]        dmag_full;
    app_pkg::ang_t      hd_ext;
    pre_t               s1_next;

    pre_t               s1_reg;
    logic [31:0]        s1_dmag_reg;
    logic               v1_reg;

    assign in_x  = s_tdata[31:0];
    assign in_y  = s_tdata[63:32];
    assign in_hd = s_tdata[79:64];
    assign in_t  = s_tdata[95:80];

    assign ds_full   = speed_reg * $signed({1'b0, in_t});
    assign tw        = 17'(turn_reg);
    assign wabs      = tw[16] ? 17'(-tw) : 17'(tw);
    assign dmag_full = wabs * in_t;
    assign hd_ext    = app_pkg::ang_t'(in_hd);

    always_comb
    begin
        s1_next.sx       = in_x;
        s1_next.sy       = in_y;
        s1_next.ds       = ds_full[31:0];
        s1_next.th       = app_pkg::wrap_pi(hd_ext <<< 17);
        s1_next.straight = in_t < app_pkg::SHORT_TIME;
        s1_next.dneg     = turn_reg[15];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg      <= s1_next;
            s1_dmag_reg <= dmag_full[31:0];
        end
    end

    // ---------------- turn magnitude mod 2pi ----------------
    logic [39:0] mag_reg [app_pkg::MOD_STEPS];
    pre_t        mpre_reg [app_pkg::MOD_STEPS];
    logic [app_pkg::MOD_STEPS-1:0] mv_reg;

    for (genvar j = 0; j < app_pkg::MOD_STEPS; j++)
    begin : g_mod
        logic [39:0] mi;
        pre_t        pi_i;
        logic [39:0] trial;

        if (j == 0)
        begin : g_first
            assign mi   = {s1_dmag_reg, 8'h00};
            assign pi_i = s1_reg;
        end
        else
        begin : g_rest
            assign mi   = mag_reg[j-1];
            assign pi_i = mpre_reg[j-1];
        end

        assign trial = app_pkg::TWO_PI_MAG << (app_pkg::MOD_STEPS - 1 - j);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[j]  <= (mi >= trial) ? (mi - trial) : mi;
                mpre_reg[j] <= pi_i;
            end
        end
    end

    // ---------------- turn angle ----------------
    logic [39:0]   mag_last;
    app_pkg::ang_t da_abs, da_next;
    pre_t          w1_reg;
    app_pkg::ang_t da_reg;
    logic          vw1_reg;

    assign mag_last = mag_reg[app_pkg::MOD_STEPS-1];
    assign da_abs   = app_pkg::ang_t'({1'b0, mag_last[app_pkg::ANG_W-2:0]});
    assign da_next  = app_pkg::wrap_pi(mpre_reg[app_pkg::MOD_STEPS-1].dneg ?
                                       -da_abs : da_abs);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= mpre_reg[app_pkg::MOD_STEPS-1];
            da_reg <= da_next;
        end
    end

    // ---------------- chord direction, end heading ----------------
    app_pkg::ang_t half;
    logic          turn_small;
    side_t         s2_next;
    side_t         s2_reg;
    app_pkg::ang_t dir_next, dir2_reg;
    logic          v2_reg;

    assign half       = da_reg >>> 1;
    assign turn_small = (da_reg < app_pkg::SMALL_TURN) && (da_reg > -app_pkg::SMALL_TURN);

    always_comb
    begin
        s2_next.sx       = w1_reg.sx;
        s2_next.sy       = w1_reg.sy;
        s2_next.ds       = w1_reg.ds;
        s2_next.half     = half;
        s2_next.hd_ang   = app_pkg::wrap_pi(w1_reg.th + da_reg);
        s2_next.chord_ds = w1_reg.straight || turn_small;
        dir_next         = w1_reg.straight ? w1_reg.th
                                           : app_pkg::wrap_pi(w1_reg.th + half);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg   <= s2_next;
            dir2_reg <= dir_next;
        end
    end

    // ---------------- two CORDICs side by side ----------------
    app_pkg::xy_t ha_cos, ha_sin, dr_cos, dr_sin;

    app_cordic u_cordic_half (
        .clk     (clk),
        .en      (en),
        .ang     (s2_reg.half),
        .cos_val (ha_cos),
        .sin_val (ha_sin)
    );

    app_cordic u_cordic_dir (
        .clk     (clk),
        .en      (en),
        .ang     (dir2_reg),
        .cos_val (dr_cos),
        .sin_val (dr_sin)
    );

    side_t                   cside_reg [app_pkg::CL];
    logic [app_pkg::CL-1:0]  cv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cside_reg[0] <= s2_reg;
            for (int i = 1; i < app_pkg::CL; i++)
                cside_reg[i] <= cside_reg[i-1];
        end
    end

    // ---------------- sin(h)/h divider ----------------
    join_t                         jn;
    logic signed [app_pkg::FW-1:0] f_q30;
    join_t                         dside_reg [app_pkg::DL];
    logic [app_pkg::DL-1:0]        dv_reg;

    // ha_cos is not needed: only sin(h) enters the ratio
    assign jn.sx       = cside_reg[app_pkg::CL-1].sx;
    assign jn.sy       = cside_reg[app_pkg::CL-1].sy;
    assign jn.ds       = cside_reg[app_pkg::CL-1].ds;
    assign jn.hd_ang   = cside_reg[app_pkg::CL-1].hd_ang;
    assign jn.chord_ds = cside_reg[app_pkg::CL-1].chord_ds;
    assign jn.c        = dr_cos;
    assign jn.s        = dr_sin;

    app_div u_div (
        .clk  (clk),
        .en   (en),
        .num  (ha_sin),
        .den  (cside_reg[app_pkg::CL-1].half),
        .quot (f_q30)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside_reg[0] <= jn;
            for (int i = 1; i < app_pkg::DL; i++)
                dside_reg[i] <= dside_reg[i-1];
        end
    end

    // ---------------- chord and steps ----------------
    logic signed [65:0]            m1_prod_reg;
    join_t                         m1_reg;
    logic                          vm1_reg;

    logic signed [65:0]            cr;
    logic signed [app_pkg::CH_W-1:0] chord_next, chord_reg;
    join_t                         m2_reg;
    logic                          vm2_reg;

    logic signed [69:0]            px_reg, py_reg;
    join_t                         m3_reg;
    logic                          vm3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_prod_reg <= dside_reg[app_pkg::DL-1].ds * f_q30;
            m1_reg      <= dside_reg[app_pkg::DL-1];
        end
    end

    assign cr         = m1_prod_reg + (66'sd1 <<< 29);
    assign chord_next = m1_reg.chord_ds ? app_pkg::CH_W'(m1_reg.ds) : cr[65:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chord_reg <= chord_next;
            m2_reg    <= m1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= chord_reg * m2_reg.c;
            py_reg <= chord_reg * m2_reg.s;
            m3_reg <= m2_reg;
        end
    end

    // ---------------- output word ----------------
    logic signed [69:0] rx, ry;
    logic signed [34:0] exs, eys, hr;
    logic signed [31:0] ex_next, ey_next;
    logic signed [31:0] end_x_reg, end_y_reg;
    logic signed [15:0] end_hd_reg;
    logic               m_valid_reg;

    assign rx  = px_reg + (70'sd1 <<< 35);
    assign ry  = py_reg + (70'sd1 <<< 35);
    assign exs = 35'(m3_reg.sx) + 35'($signed(rx[69:36]));
    assign eys = 35'(m3_reg.sy) + 35'($signed(ry[69:36]));
    assign hr  = m3_reg.hd_ang + (35'sd1 <<< 16);

    always_comb
    begin
        if (exs > 35'sd2147483647)
            ex_next = 32'sh7fffffff;
        else if (exs < -35'sd2147483648)
            ex_next = 32'sh80000000;
        else
            ex_next = exs[31:0];

        if (eys > 35'sd2147483647)
            ey_next = 32'sh7fffffff;
        else if (eys < -35'sd2147483648)
            ey_next = 32'sh80000000;
        else
            ey_next = eys[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            end_x_reg  <= ex_next;
            end_y_reg  <= ey_next;
            end_hd_reg <= hr[32:17];
        end
    end

    // ---------------- valid bits, global advance ----------------
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            mv_reg      <= '0;
            vw1_reg     <= 1'b0;
            v2_reg      <= 1'b0;
            cv_reg      <= '0;
            dv_reg      <= '0;
            vm1_reg     <= 1'b0;
            vm2_reg     <= 1'b0;
            vm3_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= s_tvalid;
            mv_reg      <= {mv_reg[app_pkg::MOD_STEPS-2:0], v1_reg};
            vw1_reg     <= mv_reg[app_pkg::MOD_STEPS-1];
            v2_reg      <= vw1_reg;
            cv_reg      <= {cv_reg[app_pkg::CL-2:0], v2_reg};
            dv_reg      <= {dv_reg[app_pkg::DL-2:0], cv_reg[app_pkg::CL-1]};
            vm1_reg     <= dv_reg[app_pkg::DL-1];
            vm2_reg     <= vm1_reg;
            vm3_reg     <= vm2_reg;
            m_valid_reg <= vm3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {end_hd_reg, end_y_reg, end_x_reg};

    // ---------------- checks ----------------
    `ASSERT_CLK(a_entry_valid, (s_tvalid && s_tready) |=> v1_reg, "accepted word lost")
    `ASSERT_CLK(a_stall_hold, !en |=> ($stable(cv_reg) && $stable(dv_reg)), "moved in stall")
    `ASSERT_CLK(a_dir_range, v2_reg |-> (dir2_reg <= app_pkg::PI && dir2_reg > -app_pkg::PI), "dir")
    `ASSERT_ALWAYS(a_hd_range, m_valid_reg |-> (end_hd_reg <= 16'sd25736 && end_hd_reg >= -16'sd25736), "hd")

endmodule

`default_nettype wire
